[hw/rtl/tsr_pkg.sv]
`default_nettype none

package tsr_pkg;

    // Block geometry of the archive.
    localparam int BLOCK_LEN = 512;
    localparam int OFF_W     = 9;
    localparam int NAME_LEN  = 100;

    // Header field offsets. Each octal field runs up to the start of the next one.
    localparam int OFF_MODE  = 100;
    localparam int OFF_UID   = 108;
    localparam int OFF_GID   = 116;
    localparam int OFF_SIZE  = 124;
    localparam int OFF_MTIME = 136;
    localparam int OFF_CHK   = 148;
    localparam int OFF_TYPE  = 156;

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_5     = 8'h35;
    localparam logic [7:0] CHAR_7     = 8'h37;

    // Mode bit that marks a directory.
    localparam logic [20:0] DIR_BIT = 21'o0040000;

    // At most two result words follow from one input byte.
    localparam int MAX_RES = 2;

    // Result event codes.
    localparam logic [2:0] EV_NAME      = 3'd0;
    localparam logic [2:0] EV_HEADER    = 3'd1;
    localparam logic [2:0] EV_DATA      = 3'd2;
    localparam logic [2:0] EV_FILE_DONE = 3'd3;
    localparam logic [2:0] EV_ARCH_DONE = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;

    // Error codes.
    localparam logic [1:0] ERR_FIELD  = 2'd0;
    localparam logic [1:0] ERR_TYPE   = 2'd1;
    localparam logic [1:0] ERR_CHKSUM = 2'd2;
    localparam logic [1:0] ERR_PAD    = 2'd3;

    // Stream position of the parser.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DATA,
        PH_PAD,
        PH_FIN1,
        PH_FIN2,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // Position within one octal field.
    typedef enum logic [1:0] {
        FP_LEAD,
        FP_DIGITS,
        FP_TRAIL,
        FP_BAD
    } t_fphase;

    // Sticky per-header status.
    typedef struct packed {
        logic name_done;
        logic hdr_bad;
        logic is_dir;
        logic type_bad;
        logic chk_bad;
    } t_flags;

    // Control from the parser to the octal field accumulator.
    typedef struct packed {
        logic step;
        logic first;
    } t_field_ctl;

    // Status from the octal field accumulator.
    typedef struct packed {
        logic [32:0] value;
        logic        end_ok;
    } t_field_sts;

    // One result word.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  out_byte;
        logic [20:0] file_mode;
        logic [20:0] owner_id;
        logic [20:0] group_id;
        logic [32:0] file_size;
        logic [31:0] mod_time;
        logic        is_directory;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/tsr_if.sv]
`default_nettype none

// Input channel: one archive byte per word.
interface tsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

// Result channel: one parser event per word.
interface tsr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  out_byte;
    logic [20:0] file_mode;
    logic [20:0] owner_id;
    logic [20:0] group_id;
    logic [32:0] file_size;
    logic [31:0] mod_time;
    logic        is_directory;
    logic [1:0]  error_code;
    logic        last;

    modport source (
        output valid, output event_res, output out_byte, output file_mode,
        output owner_id, output group_id, output file_size, output mod_time,
        output is_directory, output error_code, output last, input ready
    );
    modport sink (
        input valid, input event_res, input out_byte, input file_mode,
        input owner_id, input group_id, input file_size, input mod_time,
        input is_directory, input error_code, input last, output ready
    );
endinterface

`default_nettype wire

[hw/rtl/tsr_field.sv]
`default_nettype none

// Octal field accumulator: leading fill, digits, trailing fill.
module tsr_field (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tsr_pkg::t_field_ctl i_ctl,
    input  wire  [7:0]          i_byte,
    output tsr_pkg::t_field_sts o_sts
);
    import tsr_pkg::*;

    t_fphase     r_phase;
    t_fphase     n_phase;
    logic [32:0] r_value;
    logic [32:0] n_value;
    t_fphase     eff_phase;
    logic [32:0] eff_value;
    logic        is_fill;
    logic        is_digit;

    // Byte classes.
    assign is_fill  = (i_byte == CHAR_SPACE) || (i_byte == CHAR_NUL);
    assign is_digit = (i_byte >= CHAR_0) && (i_byte <= CHAR_7);

    // The first byte of a field starts from a clean accumulator.
    assign eff_phase = i_ctl.first ? FP_LEAD : r_phase;
    assign eff_value = i_ctl.first ? 33'd0 : r_value;

    // Next state of the field scanner.
    always_comb begin
        n_phase = r_phase;
        n_value = r_value;
        if (i_ctl.step) begin
            n_phase = eff_phase;
            n_value = eff_value;
            case (eff_phase)
                FP_LEAD: begin
                    if (is_digit) begin
                        n_phase = FP_DIGITS;
                        n_value = {30'd0, i_byte[2:0]};
                    end else if (!is_fill) begin
                        n_phase = FP_BAD;
                    end
                end
                FP_DIGITS: begin
                    if (is_digit) begin
                        n_value = {eff_value[29:0], i_byte[2:0]};
                    end else if (is_fill) begin
                        n_phase = FP_TRAIL;
                    end else begin
                        n_phase = FP_BAD;
                    end
                end
                FP_TRAIL: begin
                    if (!is_fill) begin
                        n_phase = FP_BAD;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // A field is good when its closing byte is fill and a digit was seen.
    always_comb begin
        o_sts.value  = r_value;
        o_sts.end_ok = is_fill && ((r_phase == FP_DIGITS) || (r_phase == FP_TRAIL));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= FP_LEAD;
            r_value <= 33'd0;
        end else begin
            r_phase <= n_phase;
            r_value <= n_value;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsr_parser.sv]
`default_nettype none

// Stream parser: block position, header checks and result words for each byte.
module tsr_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_byte,
    input  tsr_pkg::t_field_sts i_fld,
    output tsr_pkg::t_field_ctl o_fld_ctl,
    output tsr_pkg::t_result    o_res0,
    output tsr_pkg::t_result    o_res1,
    output logic [1:0]          o_count
);
    import tsr_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [OFF_W-1:0]   r_off;
    logic [OFF_W-1:0]   n_off;
    logic [16:0]        r_sum;
    logic [16:0]        n_sum;
    logic [20:0]        r_mode;
    logic [20:0]        n_mode;
    logic [20:0]        r_uid;
    logic [20:0]        n_uid;
    logic [20:0]        r_gid;
    logic [20:0]        n_gid;
    logic [31:0]        r_mtime;
    logic [31:0]        n_mtime;
    logic [32:0]        r_rem;
    logic [32:0]        n_rem;
    t_flags             r_flags;
    t_flags             n_flags;

    logic               live;
    logic               at_end;
    logic               lead_nul;
    logic               hdr_byte;
    t_flags             flags_base;
    logic               in_chk;
    logic [16:0]        sum_next;
    logic               in_fields;
    logic               is_first;
    logic               is_last;
    logic               name_emit;
    logic               hdr_fail;
    logic [1:0]         hdr_err;
    logic [32:0]        rem_dec;
    logic               data_zero;
    logic               nonzero;

    // Byte decode shared by the state update and the result words.
    assign live     = i_valid && (r_phase != PH_DONE) && (r_phase != PH_ERROR);
    assign at_end   = (r_off == OFF_W'(BLOCK_LEN - 1));
    assign nonzero  = (i_byte != CHAR_NUL);
    assign lead_nul = (r_off == '0) && !nonzero;
    assign hdr_byte = live && (r_phase == PH_HEADER) && !lead_nul;

    // A new header block starts its flags and checksum from zero.
    assign flags_base = (r_off == '0) ? '0 : r_flags;
    assign in_chk     = (r_off >= OFF_W'(OFF_CHK)) && (r_off < OFF_W'(OFF_TYPE));
    assign sum_next   = ((r_off == '0) ? 17'd0 : r_sum)
                      + (in_chk ? {9'd0, CHAR_SPACE} : {9'd0, i_byte});

    // Octal field boundaries.
    assign in_fields = (r_off >= OFF_W'(OFF_MODE)) && (r_off < OFF_W'(OFF_TYPE));
    assign is_first  = (r_off == OFF_W'(OFF_MODE)) || (r_off == OFF_W'(OFF_UID))
                    || (r_off == OFF_W'(OFF_GID)) || (r_off == OFF_W'(OFF_SIZE))
                    || (r_off == OFF_W'(OFF_MTIME)) || (r_off == OFF_W'(OFF_CHK));
    assign is_last   = (r_off == OFF_W'(OFF_UID - 1)) || (r_off == OFF_W'(OFF_GID - 1))
                    || (r_off == OFF_W'(OFF_SIZE - 1)) || (r_off == OFF_W'(OFF_MTIME - 1))
                    || (r_off == OFF_W'(OFF_CHK - 1)) || (r_off == OFF_W'(OFF_TYPE - 1));

    always_comb begin
        o_fld_ctl.step  = hdr_byte && in_fields && !is_last;
        o_fld_ctl.first = is_first;
    end

    assign name_emit = hdr_byte && (r_off < OFF_W'(NAME_LEN)) && !flags_base.name_done
                    && nonzero;

    // Header verdict at the last byte of the block; the checksum field value is
    // still held by the accumulator there.
    assign hdr_fail = flags_base.hdr_bad || flags_base.type_bad || flags_base.chk_bad
                   || (i_fld.value != {16'd0, sum_next});
    assign hdr_err  = flags_base.hdr_bad  ? ERR_FIELD :
                      flags_base.type_bad ? ERR_TYPE  : ERR_CHKSUM;

    assign rem_dec   = r_rem - 33'd1;
    assign data_zero = (rem_dec == 33'd0);

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_off   = r_off;
        n_sum   = r_sum;
        n_mode  = r_mode;
        n_uid   = r_uid;
        n_gid   = r_gid;
        n_mtime = r_mtime;
        n_rem   = r_rem;
        n_flags = r_flags;
        if (live) begin
            n_off = r_off + OFF_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (lead_nul) begin
                        n_phase = PH_FIN1;
                    end else begin
                        n_sum   = sum_next;
                        n_flags = flags_base;
                        if ((r_off < OFF_W'(NAME_LEN)) && !nonzero) begin
                            n_flags.name_done = 1'b1;
                        end
                        if (r_off == OFF_W'(OFF_UID - 1)) begin
                            if (i_fld.end_ok) n_mode = i_fld.value[20:0];
                            else n_flags.hdr_bad = 1'b1;
                        end
                        if (r_off == OFF_W'(OFF_GID - 1)) begin
                            if (i_fld.end_ok) n_uid = i_fld.value[20:0];
                            else n_flags.hdr_bad = 1'b1;
                        end
                        if (r_off == OFF_W'(OFF_SIZE - 1)) begin
                            if (i_fld.end_ok) n_gid = i_fld.value[20:0];
                            else n_flags.hdr_bad = 1'b1;
                        end
                        if (r_off == OFF_W'(OFF_MTIME - 1)) begin
                            if (i_fld.end_ok) n_rem = i_fld.value;
                            else n_flags.hdr_bad = 1'b1;
                        end
                        if (r_off == OFF_W'(OFF_CHK - 1)) begin
                            if (i_fld.end_ok && !i_fld.value[32]) n_mtime = i_fld.value[31:0];
                            else n_flags.hdr_bad = 1'b1;
                        end
                        if ((r_off == OFF_W'(OFF_TYPE - 1)) && !i_fld.end_ok) begin
                            n_flags.chk_bad = 1'b1;
                        end
                        if (r_off == OFF_W'(OFF_TYPE)) begin
                            if (i_byte == CHAR_5) n_flags.is_dir = 1'b1;
                            else if (i_byte != CHAR_0) n_flags.type_bad = 1'b1;
                        end
                        if (at_end) begin
                            if (hdr_fail) n_phase = PH_ERROR;
                            else if (r_rem != 33'd0) n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_rem = rem_dec;
                    if (data_zero) begin
                        n_phase = at_end ? PH_HEADER : PH_PAD;
                    end
                end
                PH_PAD: begin
                    if (nonzero) n_phase = PH_ERROR;
                    else if (at_end) n_phase = PH_HEADER;
                end
                PH_FIN1, PH_FIN2: begin
                    if (nonzero) begin
                        n_phase = PH_ERROR;
                    end else if (at_end) begin
                        n_phase = (r_phase == PH_FIN1) ? PH_FIN2 : PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result words for this byte; the final one carries the last mark.
    always_comb begin
        o_res0  = '0;
        o_res1  = '0;
        o_count = 2'd0;
        if (live) begin
            case (r_phase)
                PH_HEADER: begin
                    if (name_emit) begin
                        o_res0.event_res = EV_NAME;
                        o_res0.out_byte  = i_byte;
                        o_count          = 2'd1;
                    end
                    if (hdr_byte && at_end) begin
                        if (hdr_fail) begin
                            o_res0.event_res  = EV_ERROR;
                            o_res0.error_code = hdr_err;
                            o_count           = 2'd1;
                        end else begin
                            o_res0.event_res    = EV_HEADER;
                            o_res0.file_mode    = r_mode | (flags_base.is_dir ? DIR_BIT : '0);
                            o_res0.owner_id     = r_uid;
                            o_res0.group_id     = r_gid;
                            o_res0.file_size    = r_rem;
                            o_res0.mod_time     = r_mtime;
                            o_res0.is_directory = flags_base.is_dir;
                            if (r_rem == 33'd0) begin
                                o_res1.event_res = EV_FILE_DONE;
                                o_count          = 2'd2;
                            end else begin
                                o_count = 2'd1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    o_res0.event_res = EV_DATA;
                    o_res0.out_byte  = i_byte;
                    if (data_zero && at_end) begin
                        o_res1.event_res = EV_FILE_DONE;
                        o_count          = 2'd2;
                    end else begin
                        o_count = 2'd1;
                    end
                end
                PH_PAD: begin
                    if (nonzero) begin
                        o_res0.event_res  = EV_ERROR;
                        o_res0.error_code = ERR_PAD;
                        o_count           = 2'd1;
                    end else if (at_end) begin
                        o_res0.event_res = EV_FILE_DONE;
                        o_count          = 2'd1;
                    end
                end
                PH_FIN1, PH_FIN2: begin
                    if (nonzero) begin
                        o_res0.event_res  = EV_ERROR;
                        o_res0.error_code = ERR_PAD;
                        o_count           = 2'd1;
                    end else if (at_end && (r_phase == PH_FIN2)) begin
                        o_res0.event_res = EV_ARCH_DONE;
                        o_count          = 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        o_res0.last = (o_count == 2'd1);
        o_res1.last = (o_count == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off   <= '0;
            r_sum   <= '0;
            r_mode  <= '0;
            r_uid   <= '0;
            r_gid   <= '0;
            r_mtime <= '0;
            r_rem   <= '0;
            r_flags <= '0;
        end else begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_sum   <= n_sum;
            r_mode  <= n_mode;
            r_uid   <= n_uid;
            r_gid   <= n_gid;
            r_mtime <= n_mtime;
            r_rem   <= n_rem;
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsr_queue.sv]
`default_nettype none

// Result queue: takes up to two words a cycle, hands out one while the reader is ready.
module tsr_queue #(
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [1:0]       i_wr_count,
    input  tsr_pkg::t_result i_wr0,
    input  tsr_pkg::t_result i_wr1,
    output logic             o_space_ok,
    output logic             o_valid,
    output tsr_pkg::t_result o_data,
    input  wire              i_ready
);
    import tsr_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [IDX_W-1:0]   r_wr;
    logic [IDX_W-1:0]   n_wr;
    logic [IDX_W-1:0]   r_rd;
    logic [IDX_W-1:0]   n_rd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   wr_next;
    logic               pop;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    // Room for a full pair is needed before the next byte is taken.
    assign o_space_ok = (r_count <= CNT_W'(DEPTH - MAX_RES));
    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rd];
    assign pop        = o_valid && i_ready;
    assign wr_next    = wrap_inc(r_wr);

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = pop ? wrap_inc(r_rd) : r_rd;
        n_count = r_count + CNT_W'(i_wr_count) - CNT_W'(pop);
        case (i_wr_count)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = wrap_inc(wr_next);
            default: n_wr = r_wr;
        endcase
    end

    // Storage of the queued words.
    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr] <= i_wr0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[wr_next] <= i_wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tar_stream_reader_top.sv]
`default_nettype none

// Channel   Direction  Word contents
// i_in      in         stream_byte: next byte of the archive
// o_res     out        event_res, out_byte, header fields, error_code, last
//
// One archive byte is taken per cycle while the queue has room. Its results are written
// into the result queue at the edge that accepts it, so with an empty queue the first
// result is offered in the next cycle. A byte can produce two words (header plus file
// done, last data byte plus file done); the queue drains one word per cycle while o_res
// is ready; input is held off with fewer than two free entries. Reset has no sweep.
// A stalled output stops input once the queue holds more than QUEUE_DEPTH - 2 words.
module tar_stream_reader_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input wire        i_clk,
    input wire        i_rst_n,
    tsr_in_if.sink    i_in,
    tsr_out_if.source o_res
);
    import tsr_pkg::*;

    t_field_ctl fld_ctl;
    t_field_sts fld_sts;
    t_result    res0;
    t_result    res1;
    t_result    q_data;
    logic [1:0] wr_count;
    logic       space_ok;
    logic       q_valid;
    logic       accept;

    assign i_in.ready = space_ok;
    assign accept     = i_in.valid && space_ok;

    // Octal field accumulator.
    tsr_field u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fld_ctl),
        .i_byte  (i_in.stream_byte),
        .o_sts   (fld_sts)
    );

    // Stream parser.
    tsr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_byte    (i_in.stream_byte),
        .i_fld     (fld_sts),
        .o_fld_ctl (fld_ctl),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_count   (wr_count)
    );

    // Result queue in front of the output channel.
    tsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (wr_count),
        .i_wr0      (res0),
        .i_wr1      (res1),
        .o_space_ok (space_ok),
        .o_valid    (q_valid),
        .o_data     (q_data),
        .i_ready    (o_res.ready)
    );

    // Output word fields.
    assign o_res.valid        = q_valid;
    assign o_res.event_res    = q_data.event_res;
    assign o_res.out_byte     = q_data.out_byte;
    assign o_res.file_mode    = q_data.file_mode;
    assign o_res.owner_id     = q_data.owner_id;
    assign o_res.group_id     = q_data.group_id;
    assign o_res.file_size    = q_data.file_size;
    assign o_res.mod_time     = q_data.mod_time;
    assign o_res.is_directory = q_data.is_directory;
    assign o_res.error_code   = q_data.error_code;
    assign o_res.last         = q_data.last;

    // Input is only held off while the queue has words waiting.
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_res.valid)
        else $error("input stalled with an empty result queue");

    // A pair of words always ends in file done, marked last only on the second.
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_count == 2'd2) |-> ((res1.event_res == EV_FILE_DONE) && res1.last && !res0.last))
        else $error("bad two-word result");

    // A single word carries the last mark.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_count == 2'd1) |-> res0.last)
        else $error("single result word without last mark");

    // Once an error or archive done word is delivered the parser stays silent.
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready
         && ((o_res.event_res == EV_ERROR) || (o_res.event_res == EV_ARCH_DONE)))
        |=> (wr_count == 2'd0))
        else $error("result produced after the end of the stream");

endmodule

`default_nettype wire
